FILE: sv/prac_pkg.sv
// types, constants and arithmetic helpers for the pixel residual add and convert block
package prac_pkg;

  localparam int unsigned PIX_W = 16;
  localparam int unsigned FMT_W = 3;
  localparam int unsigned IDX_W = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_OPERATION  = 2'd0,
    REG_SRC_FORMAT = 2'd1,
    REG_DST_FORMAT = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_t;

  localparam logic OP_COPY = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  localparam logic [FMT_W-1:0] FMT_U8   = 3'd0;
  localparam logic [FMT_W-1:0] FMT_S8_7 = 3'd4;

  typedef struct packed {
    logic             operation;
    logic [FMT_W-1:0] src_format;
    logic [FMT_W-1:0] dst_format;
  } cfg_t;

  typedef logic [PIX_W-1:0] pix_t;

  // per unsigned format (u8, u10, u12, u14): shift to q15, rounding, midpoint, max
  localparam logic [2:0]   SHIFT_TAB [4] = '{3'd7, 3'd5, 3'd3, 3'd1};
  localparam logic [15:0]  ROUND_TAB [4] = '{16'h0040, 16'h0010, 16'h0004, 16'h0001};
  localparam logic [15:0]  HALF_TAB  [4] = '{16'h0080, 16'h0200, 16'h0800, 16'h2000};
  localparam logic [15:0]  MAX_TAB   [4] = '{16'd255, 16'd1023, 16'd4095, 16'd16383};
  localparam logic [15:0]  OFFSET    = 16'h4000;

  function automatic pix_t sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'h7fff;
    end else if (v < -18'sd32768) begin
      return 16'h8000;
    end else begin
      return v[15:0];
    end
  endfunction

  function automatic pix_t sat_add(input pix_t a, input pix_t b);
    logic signed [17:0] sum;
    sum = $signed({{2{a[15]}}, a}) + $signed({{2{b[15]}}, b});
    return sat16(sum);
  endfunction

  // unsigned n-bit value moved up to q15 and recentered
  function automatic pix_t u_to_s(input pix_t v, input logic [2:0] sh);
    logic [22:0] wide;
    wide = {7'b0, v} << sh;
    return wide[15:0] - OFFSET;
  endfunction

  // signed 16-bit value rounded and shifted down to unsigned format f
  function automatic pix_t s16_to_u(input pix_t s, input logic [1:0] f);
    pix_t               r;
    logic signed [15:0] a;
    logic signed [17:0] u;
    r = sat_add(s, ROUND_TAB[f]);
    a = $signed(r) >>> SHIFT_TAB[f];
    u = $signed({{2{a[15]}}, a}) + $signed({2'b0, HALF_TAB[f]});
    if (u[17]) begin
      return '0;
    end else if (u[16:0] > {1'b0, MAX_TAB[f]}) begin
      return MAX_TAB[f];
    end else begin
      return u[15:0];
    end
  endfunction

endpackage

FILE: sv/prac_in_if.sv
// input word channel: base pixel and source value
interface prac_in_if;
  import prac_pkg::*;
  logic valid;
  logic ready;
  pix_t base_pixel;
  pix_t source_value;
  modport source (output valid, output base_pixel, output source_value, input ready);
  modport sink (input valid, input base_pixel, input source_value, output ready);
endinterface

FILE: sv/prac_out_if.sv
// output word channel: result pixel and unsupported flag
interface prac_out_if;
  import prac_pkg::*;
  logic valid;
  logic ready;
  pix_t result_pixel;
  logic unsupported;
  modport source (output valid, output result_pixel, output unsupported, input ready);
  modport sink (input valid, input result_pixel, input unsupported, output ready);
endinterface

FILE: sv/prac_cfg_if.sv
// configuration write channel: register index and write data
interface prac_cfg_if;
  import prac_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [FMT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/prac_regs.sv
// configuration register file
module prac_regs import prac_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  prac_cfg_if.sink   cfg,
  output cfg_t       cfg_q
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q <= '0;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_OPERATION:  cfg_q.operation  <= cfg.data[0];
        REG_SRC_FORMAT: cfg_q.src_format <= cfg.data;
        REG_DST_FORMAT: cfg_q.dst_format <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/prac_core.sv
// blend and format conversion datapath for one word
module prac_core import prac_pkg::*; (
  input  cfg_t cfg_q,
  input  pix_t base_pixel,
  input  pix_t source_value,
  output pix_t result_pixel,
  output logic unsupported
);

  logic [1:0]         sf_lo;
  logic [1:0]         df_lo;
  logic               both_u8;
  pix_t               base_u;
  pix_t               resid;
  pix_t               start;
  logic signed [15:0] down;
  logic [2:0]         k;

  always_comb begin
    sf_lo   = cfg_q.src_format[1:0];
    df_lo   = cfg_q.dst_format[1:0];
    both_u8 = (cfg_q.src_format == FMT_U8) && (cfg_q.dst_format == FMT_U8);
    base_u  = (cfg_q.dst_format == FMT_U8) ? {8'b0, base_pixel[7:0]} : base_pixel;
    resid   = both_u8 ? {source_value[7:0], 8'b0} : source_value;
    start   = sat_add(u_to_s(base_u, SHIFT_TAB[df_lo]), resid);
    down    = $signed(source_value) >>> {sf_lo, 1'b0};
    k       = cfg_q.src_format - FMT_S8_7;
    result_pixel = '0;
    unsupported  = 1'b0;
    if (cfg_q.operation == OP_ADD) begin
      if (cfg_q.dst_format[2]) begin
        result_pixel = sat_add(base_pixel, source_value);
      end else begin
        result_pixel = s16_to_u(start, df_lo);
      end
    end else if (!cfg_q.src_format[2]) begin
      if (cfg_q.src_format == FMT_U8) begin
        if (cfg_q.dst_format == FMT_U8) begin
          unsupported = 1'b1;
        end else if (!cfg_q.dst_format[2]) begin
          result_pixel = {8'b0, source_value[7:0]} << {df_lo, 1'b0};
        end else begin
          result_pixel = u_to_s({8'b0, source_value[7:0]}, SHIFT_TAB[2'd0]);
        end
      end else if (cfg_q.dst_format == FMT_U8) begin
        if (down[15]) begin
          result_pixel = '0;
        end else if (down[14:0] > 15'd255) begin
          result_pixel = 16'd255;
        end else begin
          result_pixel = {8'b0, down[7:0]};
        end
      end else if ({1'b0, cfg_q.dst_format} >= {1'b0, cfg_q.src_format} + 4'd4) begin
        result_pixel = u_to_s(source_value, SHIFT_TAB[sf_lo]);
      end else begin
        unsupported = 1'b1;
      end
    end else begin
      if (!cfg_q.dst_format[2] && cfg_q.dst_format >= k
          && (cfg_q.dst_format != FMT_U8 || k == FMT_U8)) begin
        result_pixel = s16_to_u(source_value, df_lo);
      end else begin
        unsupported = 1'b1;
      end
    end
  end

endmodule

FILE: sv/pixel_residual_add_and_convert.sv
// top level: input register, blend and convert datapath, result register
// an accepted word waits in the input register, then moves to the result register once that is free or being read
// throughput: one word per cycle while the output is ready, through the combinational datapath between the registers
// the input stays ready while a finished result waits, as long as one register is free
// reset clears both valid flags and sets operation, src_format and dst_format to 0
module pixel_residual_add_and_convert import prac_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  prac_cfg_if.sink  cfg,
  prac_in_if.sink   pix_in,
  prac_out_if.source pix_out
);

  cfg_t cfg_q;
  logic s1_valid;
  pix_t s1_base;
  pix_t s1_source;
  logic s2_valid;
  pix_t s2_pixel;
  logic s2_unsup;
  pix_t core_pixel;
  logic core_unsup;
  logic s2_load;
  logic s1_load;

  prac_regs u_regs (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cfg_q (cfg_q)
  );

  prac_core u_core (
    .cfg_q        (cfg_q),
    .base_pixel   (s1_base),
    .source_value (s1_source),
    .result_pixel (core_pixel),
    .unsupported  (core_unsup)
  );

  assign s2_load      = s1_valid && (!s2_valid || pix_out.ready);
  assign pix_in.ready = !s1_valid || s2_load;
  assign s1_load      = pix_in.valid && pix_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load) begin
        s2_valid <= 1'b1;
      end else if (pix_out.ready) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_base   <= pix_in.base_pixel;
      s1_source <= pix_in.source_value;
    end
    if (s2_load) begin
      s2_pixel <= core_pixel;
      s2_unsup <= core_unsup;
    end
  end

  assign pix_out.valid        = s2_valid;
  assign pix_out.result_pixel = s2_pixel;
  assign pix_out.unsupported  = s2_unsup;

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!s1_valid && !s2_valid))
    else $error("pipeline not empty after reset");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_load) |=> (s1_valid && $stable(s1_base) && $stable(s1_source)))
    else $error("input register lost a word");

  a_unsup_copy: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_unsup) |-> (cfg_q.operation == OP_COPY))
    else $error("unsupported flag raised in add mode");

endmodule

FILE: tb/tb_pixel_residual_add_and_convert.sv
// self-checking regression for the pixel residual add and convert block
`timescale 1ns / 100ps

module tb_pixel_residual_add_and_convert;
  import prac_pkg::*;

  localparam logic [FMT_W-1:0] FMT_U10   = 3'd1;
  localparam logic [FMT_W-1:0] FMT_U12   = 3'd2;
  localparam logic [FMT_W-1:0] FMT_U14   = 3'd3;
  localparam logic [FMT_W-1:0] FMT_S10_5 = 3'd5;
  localparam logic [FMT_W-1:0] FMT_S12_3 = 3'd6;
  localparam logic [FMT_W-1:0] FMT_S14_1 = 3'd7;
  localparam int NUM_SETTINGS = 128;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    pix_t result_pixel;
    logic unsupported;
  } pix_result_t;

  class pixel_checker;
    cfg_t        setting;
    pix_result_t expected_pixels[$];
    int          errors;
    int          checked;
    int          words_in;

    function new();
      setting  = '0;
      errors   = 0;
      checked  = 0;
      words_in = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [FMT_W-1:0] val);
      case (idx)
        REG_OPERATION:  setting.operation  = val[0];
        REG_SRC_FORMAT: setting.src_format = val;
        REG_DST_FORMAT: setting.dst_format = val;
        default: ;
      endcase
    endfunction

    function int sx16(logic [15:0] v);
      int r;
      r = $signed(v);
      return r;
    endfunction

    function int sat16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function int clamp_hi(int v, int hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
    endfunction

    // signed q15 value rounded into unsigned format f
    function int round_to_unsigned(int s, int f);
      int n;
      int sh;
      int t;
      n  = 8 + 2 * f;
      sh = 15 - n;
      t  = sat16(s + (1 << (sh - 1)));
      t  = (t >>> sh) + (1 << (n - 1));
      return clamp_hi(t, (1 << n) - 1);
    endfunction

    function int blend_unsigned(pix_t base, int src, int f);
      int sh;
      int b;
      int t;
      sh = 7 - 2 * f;
      b  = (f == 0) ? int'(base[7:0]) : int'(base);
      t  = sx16(16'(((b << sh) - 'h4000) & 'hffff));
      t  = sat16(t + src);
      return round_to_unsigned(t, f);
    endfunction

    function pix_result_t predict_pixel(pix_t base, pix_t src);
      pix_result_t r;
      int          sf;
      int          df;
      int          k;
      int          s8;
      int          v;
      sf = setting.src_format;
      df = setting.dst_format;
      v  = 0;
      r.unsupported = 1'b0;
      if (setting.operation == OP_ADD) begin
        if (df >= FMT_S8_7) begin
          v = sat16(sx16(base) + sx16(src));
        end else if (df == FMT_U8 && sf == FMT_U8) begin
          s8 = $signed(src[7:0]);
          v  = blend_unsigned(base, s8 * 256, 0);
        end else begin
          v = blend_unsigned(base, sx16(src), df);
        end
      end else if (sf < FMT_S8_7) begin
        if (sf == FMT_U8) begin
          if (df == FMT_U8) r.unsupported = 1'b1;
          else if (df < FMT_S8_7) v = int'(src[7:0]) << (2 * df);
          else v = (int'(src[7:0]) << 7) - 'h4000;
        end else if (df == FMT_U8) begin
          v = clamp_hi(sx16(src) >>> (2 * sf), 255);
        end else if (df >= sf + 4) begin
          v = (int'(src) << (7 - 2 * sf)) - 'h4000;
        end else begin
          r.unsupported = 1'b1;
        end
      end else begin
        k = sf - FMT_S8_7;
        if (df < FMT_S8_7 && df >= k && (df != FMT_U8 || k == 0))
          v = round_to_unsigned(sx16(src), df);
        else
          r.unsupported = 1'b1;
      end
      r.result_pixel = 16'(v);
      return r;
    endfunction

    function void note_word(pix_t base, pix_t src);
      expected_pixels.push_back(predict_pixel(base, src));
      words_in++;
    endfunction

    function void check_word(pix_t res, logic bad);
      pix_result_t exp_r;
      checked++;
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result word: result_pixel %h unsupported %b", res, bad);
        return;
      end
      exp_r = expected_pixels.pop_front();
      if (res !== exp_r.result_pixel || bad !== exp_r.unsupported) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("mismatch (op %0d src %0d dst %0d): expected %h/%b, got %h/%b",
                   setting.operation, setting.src_format, setting.dst_format,
                   exp_r.result_pixel, exp_r.unsupported, res, bad);
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   calm;
  int   hold_cycles;
  pixel_checker chk;

  prac_cfg_if cfg_bus ();
  prac_in_if  in_bus ();
  prac_out_if out_bus ();

  pixel_residual_add_and_convert u_top (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_bus),
    .pix_in  (in_bus),
    .pix_out (out_bus)
  );

  always #5 clk = ~clk;

  task automatic send_word(input pix_t b, input pix_t s);
    in_bus.valid        <= 1'b1;
    in_bus.base_pixel   <= b;
    in_bus.source_value <= s;
    do @(posedge clk); while (!in_bus.ready);
    chk.note_word(b, s);
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (chk.pending() > 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [FMT_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    chk.set_reg(idx, val);
  endtask

  task automatic set_config(input logic op, input logic [FMT_W-1:0] sf,
                            input logic [FMT_W-1:0] df);
    drain();
    write_reg(REG_OPERATION, {2'b0, op});
    write_reg(REG_SRC_FORMAT, sf);
    write_reg(REG_DST_FORMAT, df);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic pix_t pick_pix(logic [FMT_W-1:0] fmt);
    pix_t edges [6] = '{16'h0000, 16'hffff, 16'h7fff, 16'h8000, 16'h0001, 16'h00ff};
    int   n;
    pix_t v;
    n = 8 + 2 * fmt[1:0];
    case ($urandom_range(0, 7))
      0:       v = edges[$urandom_range(0, 5)];
      1, 2, 3: v = 16'($urandom);
      default: begin
        if (fmt < FMT_S8_7) v = 16'($urandom_range(0, (1 << n) - 1));
        else v = 16'($urandom_range(0, 2047)) - 16'd1024;
      end
    endcase
    return v;
  endfunction

  // receiving side with random back-pressure and the long hold
  initial begin
    int stall;
    stall = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_bus.valid && out_bus.ready)
        chk.check_word(out_bus.result_pixel, out_bus.unsupported);
      if (hold_cycles > 0) begin
        out_bus.ready <= 1'b0;
        hold_cycles--;
      end else if (stall > 0) begin
        out_bus.ready <= 1'b0;
        stall--;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        out_bus.ready <= 1'b0;
        stall = $urandom_range(1, 9) - 1;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("pixel_residual_add_and_convert regression: fail");
    $finish;
  end

  initial begin
    int   order [NUM_SETTINGS];
    int   j;
    int   tmp;
    int   count;
    logic op;
    logic [FMT_W-1:0] sf;
    logic [FMT_W-1:0] df;
    chk                 = new();
    calm                = 1'b0;
    hold_cycles         = 0;
    rst                 = 1'b1;
    in_bus.valid        = 1'b0;
    in_bus.base_pixel   = '0;
    in_bus.source_value = '0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = REG_OPERATION;
    cfg_bus.data        = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset setting: copy u8 to u8 has no conversion
    send_word(16'h0000, 16'h0000);
    send_word(16'hffff, 16'hffff);
    drain();
    write_reg(REG_UNUSED, 3'd7);
    set_config(OP_ADD, FMT_U8, FMT_U8);
    send_word(16'h00ff, 16'h007f);
    send_word(16'hff00, 16'h0080);
    send_word(16'h1234, 16'hff01);
    set_config(OP_ADD, FMT_U8, FMT_S8_7);
    send_word(16'h7fff, 16'h7fff);
    send_word(16'h8000, 16'h8000);
    send_word(16'h8000, 16'h7fff);
    set_config(OP_ADD, FMT_S10_5, FMT_U14);
    send_word(16'h3fff, 16'h7fff);
    send_word(16'h0000, 16'h8000);
    send_word(16'hffff, 16'h1234);
    set_config(OP_COPY, FMT_U8, FMT_S12_3);
    send_word(16'h0000, 16'h00ff);
    send_word(16'hffff, 16'h0000);
    set_config(OP_COPY, FMT_U8, FMT_U14);
    send_word(16'h0000, 16'h00ff);
    send_word(16'h0000, 16'hff80);
    set_config(OP_COPY, FMT_U12, FMT_U8);
    send_word(16'h0000, 16'h8000);
    send_word(16'h0000, 16'h7fff);
    send_word(16'h0000, 16'h0ff0);
    set_config(OP_COPY, FMT_U10, FMT_S10_5);
    send_word(16'h0000, 16'h03ff);
    send_word(16'h0000, 16'hffff);
    set_config(OP_COPY, FMT_S8_7, FMT_U8);
    send_word(16'h0000, 16'h7fff);
    send_word(16'h0000, 16'h8000);
    send_word(16'h0000, 16'h0000);
    set_config(OP_COPY, FMT_S14_1, FMT_U10);
    send_word(16'hffff, 16'h1234);

    // every operation and format pair once, in random order
    for (int i = 0; i < NUM_SETTINGS; i++) order[i] = i;
    for (int i = NUM_SETTINGS - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      op = order[p][6];
      sf = order[p][5:3];
      df = order[p][2:0];
      set_config(op, sf, df);
      if (p >= 110) calm = 1'b1;
      if (p == 20) begin
        hold_cycles = 60;
        for (int i = 0; i < 30; i++)
          send_word(pick_pix(df), pick_pix(op == OP_ADD ? FMT_S8_7 : sf));
      end else begin
        count = $urandom_range(6, 16);
        for (int i = 0; i < count; i++) begin
          send_word(pick_pix(df), pick_pix(op == OP_ADD ? FMT_S8_7 : sf));
          sender_gap();
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("covered %0d input words over all %0d operation and format settings",
             chk.words_in, NUM_SETTINGS);
    $display("%0d result words checked, %0d failures", chk.checked, chk.errors);
    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("pixel_residual_add_and_convert regression: pass");
    end else begin
      $display("pixel_residual_add_and_convert regression: fail");
    end
    $finish;
  end

endmodule
